// ----- src/tlpt_pkg.sv -----
// Shared types, constants and entry/flag conversion functions for the
// two-level page table manager. No dependencies.
package tlpt_pkg;

	localparam int MEM_FRAMES_DEF = 64;
	localparam int FRAME_NUM_W    = 20;
	localparam int WORD_W         = 32;
	localparam int IDX_W          = 10;
	localparam int OFFS_W         = 12;
	localparam int FLAGS_IN_W     = 8;
	localparam int FLAGS_OUT_W    = 7;
	localparam int APB_ADDR_W     = 4;
	localparam int APB_DATA_W     = 32;

	localparam logic [FRAME_NUM_W-1:0] CUR_DIR_RST    = 20'd0;
	localparam logic [FRAME_NUM_W-1:0] POOL_FIRST_RST = 20'd1;
	localparam logic [FRAME_NUM_W-1:0] POOL_LAST_RST  = 20'd63;

	localparam logic [OFFS_W-1:0] ENT_PRESENT  = 12'h001;
	localparam logic [OFFS_W-1:0] ENT_WRITE    = 12'h002;
	localparam logic [OFFS_W-1:0] ENT_USER     = 12'h004;
	localparam logic [OFFS_W-1:0] ENT_NOCACHE  = 12'h010;
	localparam logic [OFFS_W-1:0] ENT_ACCESSED = 12'h020;
	localparam logic [OFFS_W-1:0] ENT_DIRTY    = 12'h040;
	localparam logic [OFFS_W-1:0] ENT_COW      = 12'h200;

	typedef enum logic [1:0] {
		CMD_QUERY   = 2'd0,
		CMD_PROTECT = 2'd1,
		CMD_MAP     = 2'd2,
		CMD_UNMAP   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_NOT_MAPPED = 2'd1,
		ST_MISALIGNED = 2'd2,
		ST_NO_FRAME   = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		REG_CUR_DIR    = 2'd0,
		REG_POOL_FIRST = 2'd1,
		REG_POOL_LAST  = 2'd2,
		REG_NONE       = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [FRAME_NUM_W-1:0] cur_dir;
		logic [FRAME_NUM_W-1:0] pool_first;
		logic [FRAME_NUM_W-1:0] pool_last;
		logic                   reload;
		logic [FRAME_NUM_W-1:0] reload_val;
	} cfg_t;

	function automatic logic [OFFS_W-1:0] to_entry(input logic [FLAGS_IN_W-1:0] f);
		logic [OFFS_W-1:0] e;
		e = '0;
		if (f[0]) e = e | ENT_PRESENT;
		if (f[1]) e = e | ENT_WRITE;
		if (f[2]) e = e | ENT_USER;
		if (f[3]) e = e | ENT_NOCACHE;
		if (f[4]) e = e | ENT_COW;
		return e;
	endfunction

	function automatic logic [FLAGS_OUT_W-1:0] to_portable(input logic [OFFS_W-1:0] e);
		logic [FLAGS_OUT_W-1:0] f;
		f = '0;
		f[0] = |(e & ENT_PRESENT);
		f[1] = |(e & ENT_WRITE);
		f[2] = |(e & ENT_USER);
		f[3] = |(e & ENT_NOCACHE);
		f[4] = |(e & ENT_COW);
		f[5] = |(e & ENT_DIRTY);
		f[6] = |(e & ENT_ACCESSED);
		return f;
	endfunction

endpackage

// ----- src/tlpt_if.sv -----
// Request and response channel interfaces (valid/ready) of the page table manager.
// Depends on tlpt_pkg.
interface tlpt_req_if;
	logic                                 valid;
	logic                                 ready;
	logic [1:0]                           cmd;
	logic                                 use_current;
	logic [tlpt_pkg::FRAME_NUM_W-1:0]     dir_frame;
	logic [tlpt_pkg::WORD_W-1:0]          virt_addr;
	logic [tlpt_pkg::WORD_W-1:0]          phys_addr;
	logic [tlpt_pkg::FLAGS_IN_W-1:0]      flags_set;
	logic [tlpt_pkg::FLAGS_IN_W-1:0]      flags_clear;

	modport source(output valid, cmd, use_current, dir_frame, virt_addr, phys_addr,
		flags_set, flags_clear, input ready);
	modport sink(input valid, cmd, use_current, dir_frame, virt_addr, phys_addr,
		flags_set, flags_clear, output ready);
endinterface

interface tlpt_rsp_if;
	logic                                 valid;
	logic                                 ready;
	logic [1:0]                           status;
	logic [tlpt_pkg::WORD_W-1:0]          phys_out;
	logic [tlpt_pkg::FLAGS_OUT_W-1:0]     flags_out;

	modport source(output valid, status, phys_out, flags_out, input ready);
	modport sink(input valid, status, phys_out, flags_out, output ready);
endinterface

// ----- src/two_level_page_table_manager_top.sv -----
// Two-level page table manager, top level: configuration registers, walk
// sequencer and table memory. Depends on tlpt_pkg, tlpt_if, tlpt_ram,
// tlpt_cfg and tlpt_walk.
//
// Usage: requests arrive on req (cmd, use_current, dir_frame, virt_addr,
// phys_addr, flags_set, flags_clear); each produces exactly one response on
// rsp (status, phys_out, flags_out). Both are valid/ready channels; a transfer
// happens when valid and ready are high at a clock edge. Registers are written
// over the APB port (byte addresses 0, 4, 8), pready is always high.
// One request is worked at a time. Frame numbers are reduced modulo MEM_FRAMES
// by a reciprocal-multiply unit. A query, protect or unmap reads the directory
// entry, then the table entry; a map into an existing table writes the table
// entry; a map that creates a table first zero-fills it (1024-word zero-fill,
// one word per cycle on the single memory port); a misaligned request skips
// the walk. The next request is taken once the response register is loaded.
// After reset the table memory (MEM_FRAMES*1024 words) is cleared one word per
// cycle with req.ready low; register writes are taken meanwhile.
// The response register holds a finished result while rsp.ready is low; the
// next request is accepted meanwhile, and its result waits until the held one
// has been transferred.
module two_level_page_table_manager_top #(
	parameter int MEM_FRAMES = tlpt_pkg::MEM_FRAMES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	tlpt_req_if.sink                        req,
	tlpt_rsp_if.source                      rsp,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [tlpt_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [tlpt_pkg::APB_DATA_W-1:0] pwdata,
	output logic [tlpt_pkg::APB_DATA_W-1:0] prdata,
	output logic                            pready
);

	localparam int ADDR_W = $clog2(MEM_FRAMES) + tlpt_pkg::IDX_W;
	localparam int DEPTH  = MEM_FRAMES * (1 << tlpt_pkg::IDX_W);

	tlpt_pkg::cfg_t               cfg;
	logic                         ram_we;
	logic [ADDR_W-1:0]            ram_addr;
	logic [tlpt_pkg::WORD_W-1:0]  ram_wdata;
	logic [tlpt_pkg::WORD_W-1:0]  ram_rdata;

	tlpt_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	tlpt_walk #(.MEM_FRAMES(MEM_FRAMES)) u_walk (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.rsp      (rsp),
		.cfg      (cfg),
		.ram_we   (ram_we),
		.ram_addr (ram_addr),
		.ram_wdata(ram_wdata),
		.ram_rdata(ram_rdata)
	);

	tlpt_ram #(
		.WIDTH(tlpt_pkg::WORD_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

endmodule

// ----- src/tlpt_ram.sv -----
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
module tlpt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

// ----- src/tlpt_mod.sv -----
// Remainder unit: frame number modulo MEM_FRAMES by reciprocal multiplication,
// a quotient stage and a correction stage. Depends on tlpt_pkg.
module tlpt_mod #(
	parameter int MEM_FRAMES = tlpt_pkg::MEM_FRAMES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [tlpt_pkg::FRAME_NUM_W-1:0] value,
	output logic                             done,
	output logic [$clog2(MEM_FRAMES)-1:0]    rem
);

	localparam int FRAME_W = $clog2(MEM_FRAMES);
	localparam int VW      = tlpt_pkg::FRAME_NUM_W;
	localparam int SHIFT   = VW + FRAME_W;
	localparam int PW      = 2 * VW + 1;
	localparam logic [VW:0]      RECIP = (VW+1)'((64'd1 << SHIFT) / 64'(MEM_FRAMES));
	localparam logic [FRAME_W:0] MOD_L = (FRAME_W+1)'(MEM_FRAMES);

	logic               act_q;
	logic               vld_s1;
	logic               done_q;
	logic [VW-1:0]      val_q;
	logic [FRAME_W:0]   quot_s1;
	logic [FRAME_W-1:0] rem_q;
	logic [PW-1:0]      prod;
	logic [FRAME_W:0]   qm;
	logic [FRAME_W:0]   diff;
	logic [FRAME_W:0]   fixed;

	// quotient estimate is exact or one short; one subtract corrects it
	assign prod  = PW'(val_q) * PW'(RECIP);
	assign qm    = quot_s1 * MOD_L;
	assign diff  = val_q[FRAME_W:0] - qm;
	assign fixed = (diff >= MOD_L) ? (diff - MOD_L) : diff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q  <= 1'b0;
			vld_s1 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			act_q  <= start;
			vld_s1 <= act_q;
			done_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			val_q <= value;
		end
		if (act_q) begin
			quot_s1 <= prod[SHIFT +: FRAME_W+1];
		end
		if (vld_s1) begin
			rem_q <= fixed[FRAME_W-1:0];
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

// ----- src/tlpt_cfg.sv -----
// APB configuration registers: current directory frame and allocator pool bounds.
// Depends on tlpt_pkg.
module tlpt_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [tlpt_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [tlpt_pkg::APB_DATA_W-1:0] pwdata,
	output logic [tlpt_pkg::APB_DATA_W-1:0] prdata,
	output logic                            pready,
	output tlpt_pkg::cfg_t                  cfg
);

	localparam int FW = tlpt_pkg::FRAME_NUM_W;

	logic [FW-1:0]        cur_dir_q;
	logic [FW-1:0]        pool_first_q;
	logic [FW-1:0]        pool_last_q;
	logic                 wr_en;
	tlpt_pkg::reg_idx_t   idx;

	assign idx    = tlpt_pkg::reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_dir_q    <= tlpt_pkg::CUR_DIR_RST;
			pool_first_q <= tlpt_pkg::POOL_FIRST_RST;
			pool_last_q  <= tlpt_pkg::POOL_LAST_RST;
		end else if (wr_en) begin
			unique case (idx)
				tlpt_pkg::REG_CUR_DIR:    cur_dir_q    <= pwdata[FW-1:0];
				tlpt_pkg::REG_POOL_FIRST: pool_first_q <= pwdata[FW-1:0];
				tlpt_pkg::REG_POOL_LAST:  pool_last_q  <= pwdata[FW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			tlpt_pkg::REG_CUR_DIR:    prdata = {{(tlpt_pkg::APB_DATA_W-FW){1'b0}}, cur_dir_q};
			tlpt_pkg::REG_POOL_FIRST: prdata = {{(tlpt_pkg::APB_DATA_W-FW){1'b0}}, pool_first_q};
			tlpt_pkg::REG_POOL_LAST:  prdata = {{(tlpt_pkg::APB_DATA_W-FW){1'b0}}, pool_last_q};
			default:                  prdata = '0;
		endcase
	end

	assign cfg.cur_dir    = cur_dir_q;
	assign cfg.pool_first = pool_first_q;
	assign cfg.pool_last  = pool_last_q;
	assign cfg.reload     = wr_en && (idx == tlpt_pkg::REG_POOL_FIRST);
	assign cfg.reload_val = pwdata[FW-1:0];

endmodule

// ----- src/tlpt_walk.sv -----
// Walk sequencer: read-modify-write of directory and table entries in the
// table memory, frame allocator, zero-fill and clearing sweeps, response register.
// Depends on tlpt_pkg, tlpt_if and tlpt_mod.
module tlpt_walk #(
	parameter int MEM_FRAMES = tlpt_pkg::MEM_FRAMES_DEF
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	tlpt_req_if.sink                                     req,
	tlpt_rsp_if.source                                   rsp,
	input  tlpt_pkg::cfg_t                               cfg,
	output logic                                         ram_we,
	output logic [$clog2(MEM_FRAMES)+tlpt_pkg::IDX_W-1:0] ram_addr,
	output logic [tlpt_pkg::WORD_W-1:0]                  ram_wdata,
	input  logic [tlpt_pkg::WORD_W-1:0]                  ram_rdata
);

	localparam int FRAME_W = $clog2(MEM_FRAMES);
	localparam int ADDR_W  = FRAME_W + tlpt_pkg::IDX_W;
	localparam int DEPTH   = MEM_FRAMES * (1 << tlpt_pkg::IDX_W);
	localparam int FW      = tlpt_pkg::FRAME_NUM_W;
	localparam int WW      = tlpt_pkg::WORD_W;
	localparam int OW      = tlpt_pkg::OFFS_W;

	typedef enum logic [12:0] {
		S_CLEAR = 13'b0000000000001,
		S_IDLE  = 13'b0000000000010,
		S_MOD1  = 13'b0000000000100,
		S_RD1   = 13'b0000000001000,
		S_PDE   = 13'b0000000010000,
		S_ZMOD  = 13'b0000000100000,
		S_ZERO  = 13'b0000001000000,
		S_WPDE  = 13'b0000010000000,
		S_MOD2  = 13'b0000100000000,
		S_WPTE  = 13'b0001000000000,
		S_RD2   = 13'b0010000000000,
		S_PTE   = 13'b0100000000000,
		S_DONE  = 13'b1000000000000
	} state_t;

	state_t                     state_q;
	logic [ADDR_W-1:0]          addr_q;
	logic [ADDR_W-1:0]          pd_addr_q;
	logic [FW-1:0]              nf_q;
	tlpt_pkg::cmd_t             cmd_q;
	logic [WW-1:0]              va_q;
	logic [WW-1:0]              pa_q;
	logic [OW-1:0]              fset_q;
	logic [OW-1:0]              fclr_q;
	logic [WW-1:0]              pde_q;
	tlpt_pkg::status_t          status_q;
	logic [WW-1:0]              pout_q;
	logic [tlpt_pkg::FLAGS_OUT_W-1:0] fout_q;
	logic                       rsp_valid_q;
	tlpt_pkg::status_t          rsp_status_q;
	logic [WW-1:0]              rsp_phys_q;
	logic [tlpt_pkg::FLAGS_OUT_W-1:0] rsp_flags_q;

	logic                       accept;
	logic                       misalign;
	logic [FW-1:0]              dir_sel;
	logic                       pde_present;
	logic                       pde_add_user;
	logic                       alloc_ok;
	logic                       pte_present;
	logic                       out_load;
	logic                       mod_start;
	logic [FW-1:0]              mod_val;
	logic                       mod_done;
	logic [FRAME_W-1:0]         mod_rem;

	tlpt_mod #(.MEM_FRAMES(MEM_FRAMES)) u_mod (
		.clk   (clk),
		.arst_n(arst_n),
		.start (mod_start),
		.value (mod_val),
		.done  (mod_done),
		.rem   (mod_rem)
	);

	assign req.ready    = (state_q == S_IDLE);
	assign accept       = req.valid && req.ready;
	assign dir_sel      = req.use_current ? cfg.cur_dir : req.dir_frame;
	assign misalign     = ((tlpt_pkg::cmd_t'(req.cmd) == tlpt_pkg::CMD_MAP) &&
		((req.virt_addr[OW-1:0] | req.phys_addr[OW-1:0]) != '0)) ||
		((tlpt_pkg::cmd_t'(req.cmd) == tlpt_pkg::CMD_UNMAP) &&
		(req.virt_addr[OW-1:0] != '0));
	assign pde_present  = |(ram_rdata[OW-1:0] & tlpt_pkg::ENT_PRESENT);
	assign pde_add_user = |(fset_q & tlpt_pkg::ENT_USER) &&
		!(|(ram_rdata[OW-1:0] & tlpt_pkg::ENT_USER));
	assign alloc_ok     = !((nf_q < cfg.pool_first) || (nf_q > cfg.pool_last));
	assign pte_present  = pde_present;
	assign out_load     = (state_q == S_DONE) && (!rsp_valid_q || rsp.ready);

	always_comb begin
		mod_start = 1'b0;
		mod_val   = pde_q[WW-1:OW];
		ram_we    = 1'b0;
		ram_wdata = '0;
		unique case (state_q)
			S_CLEAR: ram_we = 1'b1;
			S_IDLE: begin
				mod_start = accept && !misalign;
				mod_val   = dir_sel;
			end
			S_PDE: begin
				if (cmd_q == tlpt_pkg::CMD_MAP) begin
					if (!pde_present) begin
						mod_start = alloc_ok;
						mod_val   = nf_q;
					end else begin
						mod_start = 1'b1;
						mod_val   = ram_rdata[WW-1:OW];
						ram_we    = pde_add_user;
						ram_wdata = ram_rdata | {{(WW-OW){1'b0}}, tlpt_pkg::ENT_USER};
					end
				end else begin
					mod_start = pde_present;
					mod_val   = ram_rdata[WW-1:OW];
				end
			end
			S_ZERO: ram_we = 1'b1;
			S_WPDE: begin
				ram_we    = 1'b1;
				ram_wdata = pde_q;
				mod_start = 1'b1;
			end
			S_WPTE: begin
				ram_we    = 1'b1;
				ram_wdata = pa_q | {{(WW-OW){1'b0}}, fset_q};
			end
			S_PTE: begin
				if (pte_present) begin
					unique case (cmd_q)
						tlpt_pkg::CMD_PROTECT: begin
							ram_we    = 1'b1;
							ram_wdata = {ram_rdata[WW-1:OW],
								(ram_rdata[OW-1:0] | fset_q) & ~fclr_q};
						end
						tlpt_pkg::CMD_UNMAP: ram_we = 1'b1;
						default: ;
					endcase
				end
			end
			default: ;
		endcase
	end

	assign ram_addr = addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			addr_q      <= '0;
			nf_q        <= tlpt_pkg::POOL_FIRST_RST;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg.reload) begin
				nf_q <= cfg.reload_val;
			end
			if (out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					addr_q <= addr_q + 1'b1;
					if (addr_q == ADDR_W'(DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						state_q <= misalign ? S_DONE : S_MOD1;
					end
				end
				S_MOD1: begin
					if (mod_done) begin
						addr_q  <= {mod_rem, va_q[WW-1:WW-tlpt_pkg::IDX_W]};
						state_q <= S_RD1;
					end
				end
				S_RD1: state_q <= S_PDE;
				S_PDE: begin
					if (cmd_q == tlpt_pkg::CMD_MAP) begin
						if (!pde_present) begin
							if (alloc_ok) begin
								nf_q    <= nf_q + 1'b1;
								state_q <= S_ZMOD;
							end else begin
								state_q <= S_DONE;
							end
						end else begin
							state_q <= S_MOD2;
						end
					end else begin
						state_q <= pde_present ? S_MOD2 : S_DONE;
					end
				end
				S_ZMOD: begin
					if (mod_done) begin
						addr_q  <= {mod_rem, {tlpt_pkg::IDX_W{1'b0}}};
						state_q <= S_ZERO;
					end
				end
				S_ZERO: begin
					if (&addr_q[tlpt_pkg::IDX_W-1:0]) begin
						addr_q  <= pd_addr_q;
						state_q <= S_WPDE;
					end else begin
						addr_q <= addr_q + 1'b1;
					end
				end
				S_WPDE: state_q <= S_MOD2;
				S_MOD2: begin
					if (mod_done) begin
						addr_q  <= {mod_rem, va_q[WW-tlpt_pkg::IDX_W-1:OW]};
						state_q <= (cmd_q == tlpt_pkg::CMD_MAP) ? S_WPTE : S_RD2;
					end
				end
				S_WPTE: state_q <= S_DONE;
				S_RD2:  state_q <= S_PTE;
				S_PTE:  state_q <= S_DONE;
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q    <= tlpt_pkg::cmd_t'(req.cmd);
			va_q     <= req.virt_addr;
			pa_q     <= req.phys_addr;
			fset_q   <= tlpt_pkg::to_entry(req.flags_set);
			fclr_q   <= tlpt_pkg::to_entry(req.flags_clear);
			status_q <= misalign ? tlpt_pkg::ST_MISALIGNED : tlpt_pkg::ST_OK;
			pout_q   <= '0;
			fout_q   <= '0;
		end
		if (state_q == S_PDE) begin
			pd_addr_q <= addr_q;
			if (cmd_q == tlpt_pkg::CMD_MAP) begin
				if (!pde_present) begin
					if (alloc_ok) begin
						pde_q <= {nf_q, OW'(tlpt_pkg::ENT_PRESENT | tlpt_pkg::ENT_WRITE |
							(fset_q & tlpt_pkg::ENT_USER))};
					end else begin
						status_q <= tlpt_pkg::ST_NO_FRAME;
					end
				end else begin
					pde_q <= ram_rdata | {{(WW-OW){1'b0}}, (fset_q & tlpt_pkg::ENT_USER)};
				end
			end else if (!pde_present) begin
				status_q <= tlpt_pkg::ST_NOT_MAPPED;
			end else begin
				pde_q <= ram_rdata;
			end
		end
		if (state_q == S_PTE) begin
			if (!pte_present) begin
				status_q <= tlpt_pkg::ST_NOT_MAPPED;
			end else begin
				unique case (cmd_q)
					tlpt_pkg::CMD_QUERY: begin
						pout_q <= {ram_rdata[WW-1:OW], {OW{1'b0}}};
						fout_q <= tlpt_pkg::to_portable(ram_rdata[OW-1:0]);
					end
					tlpt_pkg::CMD_UNMAP: pout_q <= {ram_rdata[WW-1:OW], {OW{1'b0}}};
					default: ;
				endcase
			end
		end
		if (out_load) begin
			rsp_status_q <= status_q;
			rsp_phys_q   <= pout_q;
			rsp_flags_q  <= fout_q;
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.status    = rsp_status_q;
	assign rsp.phys_out  = rsp_phys_q;
	assign rsp.flags_out = rsp_flags_q;

	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> !req.ready)
		else $error("request taken during clearing sweep");

	a_mod_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
		mod_done |-> (state_q == S_MOD1 || state_q == S_ZMOD || state_q == S_MOD2))
		else $error("remainder result arrived outside a wait state");

	a_alloc_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PDE && cmd_q == tlpt_pkg::CMD_MAP && !pde_present && alloc_ok)
		|=> (nf_q == $past(nf_q) + 1'b1) && (state_q == S_ZMOD))
		else $error("allocator did not advance on table creation");

	a_write_states: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == S_CLEAR || state_q == S_ZERO || state_q == S_WPDE ||
		state_q == S_WPTE || state_q == S_PDE || state_q == S_PTE))
		else $error("table memory written outside a write step");

endmodule

// ----- tb/two_level_page_table_manager_top_test.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for two_level_page_table_manager_top: drives page walk
// requests and APB register writes, predicts each response in a scoreboard.
// Depends on tlpt_pkg, tlpt_if and the two_level_page_table_manager_top RTL.

import tlpt_pkg::*;

localparam int PT_FRAMES = MEM_FRAMES_DEF;
localparam int PT_WORDS  = PT_FRAMES * 1024;

typedef struct {
	cmd_t                   cmd;
	logic                   use_current;
	logic [FRAME_NUM_W-1:0] dir_frame;
	logic [WORD_W-1:0]      virt_addr;
	logic [WORD_W-1:0]      phys_addr;
	logic [FLAGS_IN_W-1:0]  flags_set;
	logic [FLAGS_IN_W-1:0]  flags_clear;
} walk_req_t;

typedef struct {
	status_t                status;
	logic [WORD_W-1:0]      phys_out;
	logic [FLAGS_OUT_W-1:0] flags_out;
} walk_rsp_t;

class page_table_scoreboard;
	bit [31:0] words [PT_WORDS];
	bit [19:0] cur_dir    = CUR_DIR_RST;
	bit [19:0] pool_first = POOL_FIRST_RST;
	bit [19:0] pool_last  = POOL_LAST_RST;
	bit [19:0] next_free  = POOL_FIRST_RST;
	walk_rsp_t pending[$];
	int errors = 0;

	function int unsigned word_index(bit [19:0] frame, bit [9:0] idx);
		return (frame % PT_FRAMES) * 1024 + idx;
	endfunction

	function bit [11:0] entry_bits(bit [7:0] f);
		return (f[0] ? ENT_PRESENT : 12'h0) | (f[1] ? ENT_WRITE : 12'h0) |
			(f[2] ? ENT_USER : 12'h0) | (f[3] ? ENT_NOCACHE : 12'h0) |
			(f[4] ? ENT_COW : 12'h0);
	endfunction

	function bit [6:0] portable_bits(bit [11:0] e);
		return {e[5], e[6], e[9], e[4], e[2], e[1], e[0]};
	endfunction

	function void write_reg(reg_idx_t idx, bit [19:0] v);
		case (idx)
			REG_CUR_DIR: cur_dir = v;
			REG_POOL_FIRST: begin
				pool_first = v;
				next_free = v;
			end
			REG_POOL_LAST: pool_last = v;
			default: ;
		endcase
	endfunction

	function bit [19:0] reg_value(reg_idx_t idx);
		case (idx)
			REG_CUR_DIR: return cur_dir;
			REG_POOL_FIRST: return pool_first;
			REG_POOL_LAST: return pool_last;
			default: return '0;
		endcase
	endfunction

	function walk_rsp_t walk(walk_req_t r);
		walk_rsp_t res;
		bit [19:0] dir, nf;
		bit [11:0] fset, fclr, low;
		bit [31:0] pde, pte;
		int unsigned pd, pt, base;
		res.status = ST_OK;
		res.phys_out = '0;
		res.flags_out = '0;
		dir = r.use_current ? cur_dir : r.dir_frame;
		fset = entry_bits(r.flags_set);
		fclr = entry_bits(r.flags_clear);
		pd = word_index(dir, r.virt_addr[31:22]);
		pde = words[pd];
		if (r.cmd == CMD_MAP) begin
			if ((r.virt_addr[11:0] | r.phys_addr[11:0]) != 12'h0) begin
				res.status = ST_MISALIGNED;
			end else begin
				if (!pde[0]) begin
					nf = next_free;
					if (nf < pool_first || nf > pool_last) begin
						res.status = ST_NO_FRAME;
					end else begin
						next_free = nf + 20'd1;
						base = word_index(nf, 10'd0);
						for (int i = 0; i < 1024; i++)
							words[base + i] = '0;
						pde = {nf, 12'h0} | ENT_PRESENT | ENT_WRITE | (fset & ENT_USER);
						words[pd] = pde;
					end
				end else if ((fset & ENT_USER) != 12'h0 && (pde[11:0] & ENT_USER) == 12'h0) begin
					pde = pde | ENT_USER;
					words[pd] = pde;
				end
				if (res.status == ST_OK)
					words[word_index(pde[31:12], r.virt_addr[21:12])] = r.phys_addr | fset;
			end
		end else if (r.cmd == CMD_UNMAP && r.virt_addr[11:0] != 12'h0) begin
			res.status = ST_MISALIGNED;
		end else if (!pde[0]) begin
			res.status = ST_NOT_MAPPED;
		end else begin
			pt = word_index(pde[31:12], r.virt_addr[21:12]);
			pte = words[pt];
			if (!pte[0]) begin
				res.status = ST_NOT_MAPPED;
			end else begin
				case (r.cmd)
					CMD_QUERY: begin
						res.phys_out = {pte[31:12], 12'h0};
						res.flags_out = portable_bits(pte[11:0]);
					end
					CMD_PROTECT: begin
						low = (pte[11:0] | fset) & ~fclr;
						words[pt] = {pte[31:12], low};
					end
					default: begin
						res.phys_out = {pte[31:12], 12'h0};
						words[pt] = '0;
					end
				endcase
			end
		end
		return res;
	endfunction

	function void note_request(walk_req_t r);
		pending.push_back(walk(r));
	endfunction

	function void check_response(walk_rsp_t got);
		walk_rsp_t exp;
		if (pending.size() == 0) begin
			$error("response with none outstanding: status %0d phys_out %h flags_out %h",
				got.status, got.phys_out, got.flags_out);
			errors++;
			return;
		end
		exp = pending.pop_front();
		if (got.status !== exp.status) begin
			$error("status: expected %0d, got %0d", exp.status, got.status);
			errors++;
		end
		if (got.phys_out !== exp.phys_out) begin
			$error("phys_out: expected %h, got %h", exp.phys_out, got.phys_out);
			errors++;
		end
		if (got.flags_out !== exp.flags_out) begin
			$error("flags_out: expected %h, got %h", exp.flags_out, got.flags_out);
			errors++;
		end
	endfunction
endclass

module two_level_page_table_manager_top_test;
	localparam int LIMIT = 10_000_000;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  psel, penable, pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata, prdata;
	logic                  pready;
	int                    cycles = 0;
	bit                    hold_rsp = 1'b0;
	logic [19:0]           dir_choices [4];
	walk_req_t             map_targets[$];
	page_table_scoreboard  sb = new();

	tlpt_req_if req_ch();
	tlpt_rsp_if rsp_ch();

	two_level_page_table_manager_top #(.MEM_FRAMES(PT_FRAMES)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
			sb.check_response('{status_t'(rsp_ch.status), rsp_ch.phys_out, rsp_ch.flags_out});
	end

	initial begin : response_side
		int seg, mode;
		rsp_ch.ready = 1'b0;
		forever begin
			seg = $urandom_range(10, 150);
			mode = $urandom_range(0, 2);
			if (hold_rsp) begin
				hold_rsp = 1'b0;
				mode = 3;
				seg = 400;
			end
			repeat (seg) begin
				@(negedge clk);
				case (mode)
					0: rsp_ch.ready = 1'b1;
					1: rsp_ch.ready = $urandom_range(0, 1);
					2: rsp_ch.ready = ($urandom_range(0, 4) == 0);
					default: rsp_ch.ready = 1'b0;
				endcase
			end
		end
	end

	task automatic send_request(input walk_req_t r);
		@(negedge clk);
		req_ch.valid = 1'b1;
		req_ch.cmd = r.cmd;
		req_ch.use_current = r.use_current;
		req_ch.dir_frame = r.dir_frame;
		req_ch.virt_addr = r.virt_addr;
		req_ch.phys_addr = r.phys_addr;
		req_ch.flags_set = r.flags_set;
		req_ch.flags_clear = r.flags_clear;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		sb.note_request(r);
	endtask

	task automatic pause_sender(input int n);
		@(negedge clk);
		req_ch.valid = 1'b0;
		repeat (n - 1) @(negedge clk);
	endtask

	task automatic settle();
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic write_register(input reg_idx_t idx, input logic [19:0] v);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {idx, 2'b00};
		pwdata = {12'($urandom), v};
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		sb.write_reg(idx, v);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic check_register(input reg_idx_t idx);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = {idx, 2'b00};
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		if (prdata[19:0] !== sb.reg_value(idx)) begin
			$error("register %s: expected %h, got %h", idx.name(), sb.reg_value(idx),
				prdata[19:0]);
			sb.errors++;
		end
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
	endtask

	task automatic configure(input logic [19:0] cur, input logic [19:0] first,
		input logic [19:0] last);
		settle();
		write_register(REG_CUR_DIR, cur);
		write_register(REG_POOL_FIRST, first);
		write_register(REG_POOL_LAST, last);
		check_register(REG_CUR_DIR);
		check_register(REG_POOL_FIRST);
		check_register(REG_POOL_LAST);
		dir_choices = '{cur, 20'd2, 20'd41, 20'hFFFFF};
		map_targets.delete();
	endtask

	function automatic walk_req_t request_of(cmd_t c, logic uc, logic [19:0] d,
		logic [31:0] va, logic [31:0] pa, logic [7:0] fs, logic [7:0] fc);
		walk_req_t r;
		r = '{c, uc, d, va, pa, fs, fc};
		return r;
	endfunction

	function automatic walk_req_t random_request();
		walk_req_t r;
		cmd_t c;
		int pick;
		logic [9:0] di, ti;
		pick = $urandom_range(0, 99);
		c = pick < 30 ? CMD_MAP : pick < 55 ? CMD_QUERY : pick < 78 ? CMD_PROTECT : CMD_UNMAP;
		if (c != CMD_MAP && map_targets.size() > 0 && $urandom_range(0, 3) != 0) begin
			r = map_targets[$urandom_range(0, map_targets.size() - 1)];
			if (!r.use_current && $urandom_range(0, 3) == 0)
				r.dir_frame = r.dir_frame + 20'(64 * $urandom_range(1, 16383));
		end else begin
			r.use_current = ($urandom_range(0, 2) == 0);
			r.dir_frame = dir_choices[$urandom_range(0, 3)];
			case ($urandom_range(0, 3))
				0: r.dir_frame = 20'($urandom);
				1: r.dir_frame = r.dir_frame + 20'(64 * $urandom_range(0, 16383));
				default: ;
			endcase
			case ($urandom_range(0, 7))
				0, 1, 2: di = 10'd0;
				3: di = 10'd1;
				4: di = 10'h3FF;
				default: di = 10'($urandom);
			endcase
			ti = $urandom_range(0, 1) ? 10'($urandom_range(0, 7)) : 10'($urandom);
			r.virt_addr = {di, ti, 12'h0};
		end
		r.cmd = c;
		r.phys_addr = $urandom & 32'hFFFFF000;
		r.flags_set = 8'($urandom);
		if (c == CMD_MAP && $urandom_range(0, 6) != 0)
			r.flags_set[0] = 1'b1;
		r.flags_clear = 8'($urandom);
		if ($urandom_range(0, 3) != 0)
			r.flags_clear[0] = 1'b0;
		if (c == CMD_QUERY || c == CMD_PROTECT)
			r.virt_addr[11:0] = 12'($urandom);
		else if ($urandom_range(0, 9) == 0) begin
			if ($urandom_range(0, 1))
				r.virt_addr[11:0] = 12'($urandom_range(1, 4095));
			else
				r.phys_addr[11:0] = 12'($urandom_range(1, 4095));
		end
		if (c == CMD_MAP) begin
			map_targets.push_back(r);
			if (map_targets.size() > 48)
				void'(map_targets.pop_front());
		end
		return r;
	endfunction

	task automatic run_traffic(input int count);
		int left, burst;
		left = count;
		while (left > 0) begin
			burst = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
			repeat (burst) begin
				if (left > 0) begin
					send_request(random_request());
					left--;
				end
			end
			pause_sender($urandom_range(1, 12));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req_ch.valid = 1'b0;
		req_ch.cmd = CMD_QUERY;
		req_ch.use_current = 1'b0;
		req_ch.dir_frame = '0;
		req_ch.virt_addr = '0;
		req_ch.phys_addr = '0;
		req_ch.flags_set = '0;
		req_ch.flags_clear = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		configure(20'd3, 20'd8, 20'd63);
		write_register(REG_NONE, 20'hABCDE);
		send_request(request_of(CMD_QUERY, 1, 0, 32'h0040_0000, 0, 0, 0));
		send_request(request_of(CMD_MAP, 1, 0, 32'h0040_0123, 32'h0000_1000, 8'h01, 0));
		send_request(request_of(CMD_MAP, 1, 0, 32'h0040_0000, 32'h0000_1FFF, 8'h01, 0));
		send_request(request_of(CMD_UNMAP, 1, 0, 32'h0040_0800, 0, 0, 0));
		send_request(request_of(CMD_MAP, 1, 0, 32'h0040_0000, 32'hFFFF_F000, 8'hFF, 0));
		send_request(request_of(CMD_QUERY, 1, 0, 32'h0040_0FFF, 0, 0, 0));
		send_request(request_of(CMD_PROTECT, 1, 0, 32'h0040_0000, 0, 8'h00, 8'h0A));
		send_request(request_of(CMD_QUERY, 1, 0, 32'h0040_0000, 0, 0, 0));
		send_request(request_of(CMD_MAP, 1, 0, 32'h0080_0000, 32'h1234_5000, 8'h01, 0));
		send_request(request_of(CMD_MAP, 1, 0, 32'h0080_1000, 32'h2345_6000, 8'h05, 0));
		send_request(request_of(CMD_QUERY, 1, 0, 32'h0080_1000, 0, 0, 0));
		send_request(request_of(CMD_PROTECT, 1, 0, 32'h0040_0000, 8'h10, 8'h01, 0));
		send_request(request_of(CMD_QUERY, 1, 0, 32'h0040_0000, 0, 0, 0));
		send_request(request_of(CMD_PROTECT, 1, 0, 32'h0040_0000, 0, 8'h01, 8'h02));
		pause_sender(3);
		send_request(request_of(CMD_MAP, 0, 20'hFFFFF, 32'hFFFF_F000, 32'h0, 8'h13, 0));
		send_request(request_of(CMD_QUERY, 0, 20'd63, 32'hFFFF_F000, 0, 0, 0));
		send_request(request_of(CMD_UNMAP, 0, 20'hFFFFF, 32'hFFFF_F000, 0, 0, 0));
		send_request(request_of(CMD_UNMAP, 0, 20'hFFFFF, 32'hFFFF_F000, 0, 0, 0));
		send_request(request_of(CMD_QUERY, 0, 20'd63, 32'hFFFF_E000, 0, 0, 0));
		send_request(request_of(CMD_MAP, 1, 0, 32'h0040_2000, 32'hABCD_E000, 8'hE0, 0));
		send_request(request_of(CMD_QUERY, 1, 20'hFFFFF, 32'h0040_2000, 0, 0, 0));
		pause_sender(1);

		// single-frame pool that aliases the current directory, then runs dry
		configure(20'hFFFFF, 20'hFFFFF, 20'hFFFFF);
		send_request(request_of(CMD_MAP, 1, 0, 32'h00C0_0000, 32'h0000_7000, 8'h07, 0));
		send_request(request_of(CMD_MAP, 1, 0, 32'h0100_0000, 32'h0000_8000, 8'h01, 0));
		send_request(request_of(CMD_QUERY, 1, 0, 32'h00C0_0000, 0, 0, 0));
		pause_sender(1);

		configure(20'd0, 20'd0, 20'd0);
		send_request(request_of(CMD_MAP, 1, 0, 32'h0000_0000, 32'h0000_5000, 8'h03, 0));
		send_request(request_of(CMD_QUERY, 1, 0, 32'h0000_0000, 0, 0, 0));
		send_request(request_of(CMD_MAP, 1, 0, 32'h0040_0000, 32'h0000_6000, 8'h01, 0));
		pause_sender(1);

		configure(20'd5, 20'd1, 20'd63);
		hold_rsp = 1'b1;
		run_traffic(450);
		configure(20'd0, 20'd0, 20'hFFFFF);
		hold_rsp = 1'b1;
		run_traffic(450);
		configure(20'hFFFFF, 20'hFFFFF, 20'd0);
		run_traffic(400);
		configure(20'd33, 20'hFFFF0, 20'hFFFFF);
		run_traffic(450);

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (sb.errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule

// ----- sim.f -----
src/tlpt_pkg.sv
src/tlpt_if.sv
src/tlpt_ram.sv
src/tlpt_mod.sv
src/tlpt_cfg.sv
src/tlpt_walk.sv
src/two_level_page_table_manager_top.sv
tb/two_level_page_table_manager_top_test.sv
